>>> hdl/mahd_pkg.sv
// Shared types, constants and lookup tables for the MPEG audio header decoder.
package mahd_pkg;

  localparam logic [7:0] SYNC_BYTE  = 8'hff;
  localparam logic [7:0] SYNC_MASK  = 8'hf0;
  localparam logic [7:0] LAYER_MASK = 8'h06;
  localparam logic [7:0] RATE_MASK  = 8'hf0;
  localparam logic [7:0] FREQ_MASK  = 8'h0c;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_SYNC = 2'd1;
  localparam logic [1:0] STATUS_OVERRUN = 2'd2;

  localparam logic [1:0] LAYER_I   = 2'd0;
  localparam logic [1:0] LAYER_II  = 2'd1;
  localparam logic [1:0] LAYER_III = 2'd2;

  localparam logic [1:0] MODE_JOINT  = 2'd1;
  localparam logic [1:0] MODE_SINGLE = 2'd3;

  localparam logic [1:0] SFI_44K = 2'd0;
  localparam logic [1:0] SFI_48K = 2'd1;
  localparam logic [1:0] SFI_32K = 2'd2;

  localparam logic [2:0] TAB_LSF = 3'd4;
  localparam logic [5:0] SB_ALL  = 6'd32;

  // Reciprocal scale: quotient estimate is (x * recip) >> RECIP_SHIFT.
  localparam int RECIP_SHIFT = 28;

  localparam logic [8:0] RATE_KBPS [0:4][0:15] = '{
    '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
  };

  localparam logic [15:0] FS_HZ [0:1][0:3] = '{
    '{16'd44100, 16'd48000, 16'd32000, 16'd0},
    '{16'd22050, 16'd24000, 16'd16000, 16'd0}
  };

  localparam logic [5:0] L2_LIMIT [0:4] = '{6'd27, 6'd30, 6'd8, 6'd12, 6'd30};

  // Divisor per sample-rate index after common factors are taken out of the numerator.
  localparam logic [8:0]  DIV_VALUE [0:3] = '{9'd441, 9'd48, 9'd32, 9'd32};
  localparam logic [23:0] DIV_RECIP [0:3] =
    '{24'd608697, 24'd5592405, 24'd8388608, 24'd8388608};

  typedef struct packed {
    logic        bad;
    logic        swp;
    logic        lsf;
    logic [1:0]  layer;
    logic [1:0]  mode;
    logic        crc;
    logic [8:0]  kbps;
    logic [15:0] hz;
    logic [1:0]  sfi;
    logic        pad;
    logic [1:0]  ext;
    logic [15:0] avail;
  } hdr_t;

  typedef struct packed {
    logic        bad;
    logic        swp;
    logic        lsf;
    logic [1:0]  layer;
    logic [1:0]  mode;
    logic        crc;
    logic [8:0]  kbps;
    logic [15:0] hz;
    logic        pad;
    logic [15:0] avail;
    logic [2:0]  alloc_table;
    logic [5:0]  subband_limit;
    logic [5:0]  stereo_bound;
  } info_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } adv_t;

  function automatic logic hdr_ok(input logic [7:0] s, input logic [7:0] l,
                                  input logic [7:0] r);
    hdr_ok = (s == SYNC_BYTE) && ((l & SYNC_MASK) == SYNC_MASK) &&
             ((l & LAYER_MASK) != 8'd0) && ((r & RATE_MASK) != RATE_MASK) &&
             ((r & FREQ_MASK) != FREQ_MASK);
  endfunction

endpackage

>>> hdl/mahd_ifs.sv
// Valid/ready channel interfaces for header words and decoded results.
interface mahd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte0;
  logic [7:0]  byte1;
  logic [7:0]  byte2;
  logic [7:0]  byte3;
  logic [15:0] buffer_bytes;

  modport source (output valid, byte0, byte1, byte2, byte3, buffer_bytes, input ready);
  modport sink (input valid, byte0, byte1, byte2, byte3, buffer_bytes, output ready);
endinterface

interface mahd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        swapped16;
  logic        lsf;
  logic [1:0]  layer;
  logic [1:0]  channel_mode;
  logic        crc_present;
  logic [8:0]  bitrate_kbps;
  logic [15:0] sample_rate_hz;
  logic [11:0] frame_bytes;
  logic [2:0]  alloc_table;
  logic [5:0]  subband_limit;
  logic [5:0]  stereo_bound;

  modport source (output valid, status, swapped16, lsf, layer, channel_mode, crc_present,
                  bitrate_kbps, sample_rate_hz, frame_bytes, alloc_table, subband_limit,
                  stereo_bound, input ready);
  modport sink (input valid, status, swapped16, lsf, layer, channel_mode, crc_present,
                bitrate_kbps, sample_rate_hz, frame_bytes, alloc_table, subband_limit,
                stereo_bound, output ready);
endinterface

>>> hdl/mahd_parse.sv
// Stage 1: sync search in both byte orders, field extraction and rate lookups.
module mahd_parse import mahd_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [7:0]  byte0,
  input  logic [7:0]  byte1,
  input  logic [7:0]  byte2,
  input  logic [7:0]  byte3,
  input  logic [15:0] buffer_bytes,
  output hdr_t        hdr_r
);

  logic       ok_plain;
  logic       ok_swap;
  logic [7:0] h1;
  logic [7:0] h2;
  logic [7:0] h3;
  logic [1:0] layer;
  logic       lsf;
  logic [2:0] row;
  hdr_t       hdr_nxt;

  assign ok_plain = hdr_ok(byte0, byte1, byte2);
  assign ok_swap  = hdr_ok(byte1, byte0, byte3);

  always_comb begin
    if (ok_plain) begin
      h1 = byte1;
      h2 = byte2;
      h3 = byte3;
    end else begin
      h1 = byte0;
      h2 = byte3;
      h3 = byte2;
    end
  end

  assign lsf   = ~h1[3];
  assign layer = 2'd3 - h1[2:1];

  always_comb begin
    if (lsf) begin
      row = (layer == LAYER_I) ? 3'd3 : 3'd4;
    end else begin
      row = {1'b0, layer};
    end
  end

  always_comb begin
    hdr_nxt.bad   = ~ok_plain & ~ok_swap;
    hdr_nxt.swp   = ~ok_plain;
    hdr_nxt.lsf   = lsf;
    hdr_nxt.layer = layer;
    hdr_nxt.mode  = h3[7:6];
    hdr_nxt.crc   = ~h1[0];
    hdr_nxt.kbps  = RATE_KBPS[row][h2[7:4]];
    hdr_nxt.hz    = FS_HZ[lsf][h2[3:2]];
    hdr_nxt.sfi   = h2[3:2];
    hdr_nxt.pad   = h2[1];
    hdr_nxt.ext   = h3[5:4];
    hdr_nxt.avail = buffer_bytes;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hdr_r <= hdr_nxt;
    end
  end

endmodule

>>> hdl/mahd_len_div.sv
// Stages 2-4: Layer II table choice, slot numerator and reciprocal divide by rate.
module mahd_len_div import mahd_pkg::*; (
  input  logic        clk,
  input  adv_t        adv,
  input  hdr_t        hdr,
  output info_t       info_r,
  output logic [11:0] quot_r
);

  logic [8:0]  slots;
  logic [17:0] num;
  logic [8:0]  ch;
  logic [2:0]  tab;
  logic [5:0]  limit;
  logic [2:0]  ext1;
  logic [5:0]  bound;
  info_t       info2_nxt;
  info_t       info2_r;
  info_t       info3_r;
  logic [19:0] x2_nxt;
  logic [19:0] x2_r;
  logic [1:0]  sfi2_r;
  logic [43:0] prod;
  logic [19:0] x3_r;
  logic [1:0]  sfi3_r;
  logic [11:0] qest3_r;
  logic [20:0] qd;
  logic [20:0] rem;
  logic [11:0] quot_nxt;

  // Stage 2
  always_comb begin
    case (hdr.layer)
      LAYER_I:  slots = hdr.lsf ? 9'd24 : 9'd12;
      LAYER_II: slots = hdr.lsf ? 9'd288 : 9'd144;
      default:  slots = 9'd144;
    endcase
  end

  assign num = {9'd0, hdr.kbps} * {9'd0, slots};

  always_comb begin
    if (hdr.sfi == SFI_44K) begin
      x2_nxt = {2'd0, num} * 20'd10;
    end else begin
      x2_nxt = {2'd0, num};
    end
  end

  assign ch = (hdr.mode == MODE_SINGLE) ? hdr.kbps : {1'b0, hdr.kbps[8:1]};

  always_comb begin
    if (hdr.lsf) begin
      tab = TAB_LSF;
    end else if ((hdr.sfi == SFI_48K && ch >= 9'd56) || (ch >= 9'd56 && ch <= 9'd80)) begin
      tab = 3'd0;
    end else if (hdr.sfi != SFI_48K && ch >= 9'd96) begin
      tab = 3'd1;
    end else if (hdr.sfi != SFI_32K && ch <= 9'd48) begin
      tab = 3'd2;
    end else begin
      tab = 3'd3;
    end
  end

  assign limit = (hdr.layer == LAYER_II) ? L2_LIMIT[tab] : SB_ALL;
  assign ext1  = {1'b0, hdr.ext} + 3'd1;

  always_comb begin
    bound = limit;
    if (hdr.mode == MODE_JOINT && hdr.layer != LAYER_III) begin
      bound = ({1'b0, ext1, 2'b00} > limit) ? limit : {1'b0, ext1, 2'b00};
    end
  end

  always_comb begin
    info2_nxt.bad           = hdr.bad;
    info2_nxt.swp           = hdr.swp;
    info2_nxt.lsf           = hdr.lsf;
    info2_nxt.layer         = hdr.layer;
    info2_nxt.mode          = hdr.mode;
    info2_nxt.crc           = hdr.crc;
    info2_nxt.kbps          = hdr.kbps;
    info2_nxt.hz            = hdr.hz;
    info2_nxt.pad           = hdr.pad;
    info2_nxt.avail         = hdr.avail;
    info2_nxt.alloc_table   = (hdr.layer == LAYER_II) ? tab : 3'd0;
    info2_nxt.subband_limit = limit;
    info2_nxt.stereo_bound  = bound;
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      info2_r <= info2_nxt;
      x2_r    <= x2_nxt;
      sfi2_r  <= hdr.sfi;
    end
  end

  // Stage 3: quotient estimate, low by at most one
  assign prod = {24'd0, x2_r} * {20'd0, DIV_RECIP[sfi2_r]};

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      info3_r <= info2_r;
      x3_r    <= x2_r;
      sfi3_r  <= sfi2_r;
      qest3_r <= prod[RECIP_SHIFT+11:RECIP_SHIFT];
    end
  end

  // Stage 4: remainder check and correction
  assign qd       = {9'd0, qest3_r} * {12'd0, DIV_VALUE[sfi3_r]};
  assign rem      = {1'b0, x3_r} - qd;
  assign quot_nxt = (rem >= {12'd0, DIV_VALUE[sfi3_r]}) ? qest3_r + 12'd1 : qest3_r;

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      info_r <= info3_r;
      quot_r <= quot_nxt;
    end
  end

endmodule

>>> hdl/mpeg_audio_header_decode.sv
// Top level: MPEG audio frame header decoder, five-stage valid/ready pipeline.
// Throughput: one word per cycle while out_ch.ready holds; the reciprocal divide stages set the depth.
// A stalled output holds each full stage that has no empty stage after it; empty stages still fill.
// Reset clears the stage valid bits only; data registers are not reset.
module mpeg_audio_header_decode import mahd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  mahd_in_if.sink    in_ch,
  mahd_out_if.source out_ch
);

  typedef struct packed {
    logic [1:0]  status;
    logic        swapped16;
    logic        lsf;
    logic [1:0]  layer;
    logic [1:0]  channel_mode;
    logic        crc_present;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic [11:0] frame_bytes;
    logic [2:0]  alloc_table;
    logic [5:0]  subband_limit;
    logic [5:0]  stereo_bound;
  } res_t;

  logic [4:0]  v_r;
  logic [4:0]  en;
  adv_t        adv;
  hdr_t        hdr;
  info_t       info;
  logic [11:0] quot;
  logic [11:0] len_pad;
  logic [11:0] len;
  logic        free_fmt;
  res_t        res_nxt;
  res_t        res_r;

  assign en[4] = ~v_r[4] | out_ch.ready;
  assign en[3] = ~v_r[3] | en[4];
  assign en[2] = ~v_r[2] | en[3];
  assign en[1] = ~v_r[1] | en[2];
  assign en[0] = ~v_r[0] | en[1];

  assign in_ch.ready = en[0];

  assign adv.s2 = en[1];
  assign adv.s3 = en[2];
  assign adv.s4 = en[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_ch.valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
      if (en[4]) v_r[4] <= v_r[3];
    end
  end

  mahd_parse u_parse (
    .clk          (clk),
    .en           (en[0]),
    .byte0        (in_ch.byte0),
    .byte1        (in_ch.byte1),
    .byte2        (in_ch.byte2),
    .byte3        (in_ch.byte3),
    .buffer_bytes (in_ch.buffer_bytes),
    .hdr_r        (hdr)
  );

  mahd_len_div u_len_div (
    .clk    (clk),
    .adv    (adv),
    .hdr    (hdr),
    .info_r (info),
    .quot_r (quot)
  );

  // Stage 5: padding, Layer I slot scaling, buffer check
  assign len_pad  = quot + {11'd0, info.pad};
  assign len      = (info.layer == LAYER_I) ? {len_pad[9:0], 2'b00} : len_pad;
  assign free_fmt = (info.kbps == 9'd0);

  always_comb begin
    if (info.bad) begin
      res_nxt        = '0;
      res_nxt.status = STATUS_NO_SYNC;
    end else begin
      res_nxt.status         = (!free_fmt && ({4'd0, len} > info.avail)) ?
                               STATUS_OVERRUN : STATUS_OK;
      res_nxt.swapped16      = info.swp;
      res_nxt.lsf            = info.lsf;
      res_nxt.layer          = info.layer;
      res_nxt.channel_mode   = info.mode;
      res_nxt.crc_present    = info.crc;
      res_nxt.bitrate_kbps   = info.kbps;
      res_nxt.sample_rate_hz = info.hz;
      res_nxt.frame_bytes    = free_fmt ? 12'd0 : len;
      res_nxt.alloc_table    = info.alloc_table;
      res_nxt.subband_limit  = info.subband_limit;
      res_nxt.stereo_bound   = info.stereo_bound;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = v_r[4];
  assign out_ch.status         = res_r.status;
  assign out_ch.swapped16      = res_r.swapped16;
  assign out_ch.lsf            = res_r.lsf;
  assign out_ch.layer          = res_r.layer;
  assign out_ch.channel_mode   = res_r.channel_mode;
  assign out_ch.crc_present    = res_r.crc_present;
  assign out_ch.bitrate_kbps   = res_r.bitrate_kbps;
  assign out_ch.sample_rate_hz = res_r.sample_rate_hz;
  assign out_ch.frame_bytes    = res_r.frame_bytes;
  assign out_ch.alloc_table    = res_r.alloc_table;
  assign out_ch.subband_limit  = res_r.subband_limit;
  assign out_ch.stereo_bound   = res_r.stereo_bound;

endmodule
